// ===== design/iptl_pkg.sv =====
// ----------------------------------------------------------------------------
// iptl_pkg
// Shared types and constants for the IPv4 prefix trie lookup block.
// ----------------------------------------------------------------------------
package iptl_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int TAG_BITS_DEF   = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REPLACED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_MISS     = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [5:0]  prefix_len;
    logic [15:0] tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag_out;
    logic [5:0]  steps;
  } rsp_t;

  // Classified command handed from the front end to the engine.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [5:0]  len;
    logic [15:0] tag;
  } cmd_t;

endpackage

// ===== design/iptl_front.sv =====
// ----------------------------------------------------------------------------
// iptl_front
// Accept requests, clamp prefix length, and queue commands for the engine.
// ----------------------------------------------------------------------------
module iptl_front (
  input  logic           clk,
  input  logic           rst,
  input  iptl_pkg::req_t in_data,
  input  logic           in_valid,
  output logic           in_ready,
  output iptl_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_ready
);

  iptl_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  iptl_pkg::cmd_t c;

  always_comb begin
    c.op  = in_data.op;
    c.key = in_data.key;
    c.len = (in_data.prefix_len > 6'd32) ? 6'd32 : in_data.prefix_len;
    c.tag = in_data.tag;
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= c;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/iptl_engine.sv =====
// ----------------------------------------------------------------------------
// iptl_engine
// Walk the node memory one trie level per access and build the response.
// ----------------------------------------------------------------------------
module iptl_engine #(
  parameter int NODE_COUNT = iptl_pkg::NODE_COUNT_DEF,
  parameter int TAG_BITS   = iptl_pkg::TAG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  iptl_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  output iptl_pkg::rsp_t out_data,
  output logic           out_valid,
  input  logic           out_ready
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int UW = $clog2(NODE_COUNT + 1);
  localparam int NW = 2 * AW + 1 + TAG_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Node memory: {left, right, has_tag, tag}
  logic [NW-1:0] mem [NODE_COUNT];
  logic [NW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          wr_en;
  logic [AW-1:0] wr_a;
  logic [NW-1:0] wr_d;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    rdata <= mem[raddr];
  end

  state_t         state;
  iptl_pkg::cmd_t cur;
  logic [AW-1:0]  node;
  logic [5:0]     depth;
  logic [UW-1:0]  used;
  logic           found;
  logic [15:0]    best;
  logic [5:0]     steps;
  logic [1:0]     status;

  logic [AW-1:0]  lft, rgt, nxt;
  logic           ntag;
  logic [TAG_BITS-1:0] ntagv;
  logic           kbit;
  logic [UW:0]    need;
  logic [UW:0]    room;

  assign lft   = rdata[NW-1 -: AW];
  assign rgt   = rdata[NW-1-AW -: AW];
  assign ntag  = rdata[TAG_BITS];
  assign ntagv = rdata[TAG_BITS-1:0];
  assign kbit  = cur.key[5'd31 - depth[4:0]];
  assign nxt   = kbit ? rgt : lft;
  assign need  = (UW+1)'(cur.len) - (UW+1)'(depth);
  assign room  = (UW+1)'(NODE_COUNT) - {1'b0, used};
  assign raddr = node;

  assign cmd_ready = (state == S_IDLE) && !out_valid;

  // Memory write control per state.
  always_comb begin
    wr_en = 1'b0;
    wr_a  = node;
    wr_d  = rdata;
    case (state)
      S_EVAL: begin
        if (cur.op == iptl_pkg::OP_INSERT && depth == cur.len) begin
          wr_en = 1'b1;
          wr_d  = {lft, rgt, 1'b1, cur.tag[TAG_BITS-1:0]};
        end else if (cur.op == iptl_pkg::OP_REMOVE && depth == cur.len && ntag
                     && cur.key != 32'd0 && cur.len != 6'd0) begin
          wr_en = 1'b1;
          wr_d  = {lft, rgt, 1'b0, ntagv};
        end
      end
      S_ALLOC: begin
        // Link parent to the new node at index used.
        wr_en = 1'b1;
        wr_d  = kbit ? {lft, used[AW-1:0], ntag, ntagv}
                     : {used[AW-1:0], rgt, ntag, ntagv};
      end
      S_WRITE: begin
        // Clear the new node; tag it if it ends the prefix.
        wr_en = 1'b1;
        wr_d  = {{(2*AW){1'b0}}, depth == cur.len,
                 (depth == cur.len) ? cur.tag[TAG_BITS-1:0] : {TAG_BITS{1'b0}}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur    <= cmd;
            node   <= '0;
            depth  <= '0;
            found  <= 1'b0;
            best   <= '0;
            steps  <= '0;
            status <= iptl_pkg::ST_MISS;
            if (cmd.op == iptl_pkg::OP_INSERT && used == '0) begin
              used  <= UW'(1);
              state <= S_WRITE;
            end else if (used == '0 || cmd.op == iptl_pkg::OP_RSVD) begin
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          case (cur.op)
            iptl_pkg::OP_INSERT: begin
              if (depth == cur.len) begin
                status <= ntag ? iptl_pkg::ST_REPLACED : iptl_pkg::ST_OK;
                state  <= S_DONE;
              end else if (nxt != '0) begin
                node  <= nxt;
                depth <= depth + 6'd1;
                state <= S_READ;
              end else if (need > room) begin
                status <= iptl_pkg::ST_FULL;
                state  <= S_DONE;
              end else begin
                state <= S_ALLOC;
              end
            end
            iptl_pkg::OP_LOOKUP: begin
              steps <= steps + 6'd1;
              if (ntag) begin
                found <= 1'b1;
                best  <= 16'(ntagv);
              end
              if (depth == 6'd32 || nxt == '0) begin
                status <= (found || ntag) ? iptl_pkg::ST_OK : iptl_pkg::ST_MISS;
                state  <= S_DONE;
              end else begin
                node  <= nxt;
                depth <= depth + 6'd1;
                state <= S_READ;
              end
            end
            default: begin
              if (depth == cur.len) begin
                if (ntag && cur.key != 32'd0 && cur.len != 6'd0) begin
                  status <= iptl_pkg::ST_OK;
                  best   <= 16'(ntagv);
                end
                state <= S_DONE;
              end else if (nxt != '0) begin
                node  <= nxt;
                depth <= depth + 6'd1;
                state <= S_READ;
              end else begin
                state <= S_DONE;
              end
            end
          endcase
        end
        S_ALLOC: begin
          node  <= used[AW-1:0];
          depth <= depth + 6'd1;
          used  <= used + UW'(1);
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (depth == cur.len) begin
            status <= iptl_pkg::ST_OK;
            state  <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_DONE: begin
          out_data.status  <= status;
          out_data.tag_out <= (status == iptl_pkg::ST_OK && cur.op != iptl_pkg::OP_INSERT)
                              ? best : 16'd0;
          out_data.steps   <= (cur.op == iptl_pkg::OP_LOOKUP) ? steps : 6'd0;
          out_valid        <= 1'b1;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/ipv4_prefix_trie_lookup.sv =====
// ----------------------------------------------------------------------------
// ipv4_prefix_trie_lookup
// Binary trie longest-prefix match over IPv4 keys with insert and remove.
// ----------------------------------------------------------------------------
// One transaction runs at a time through a node memory walk: each trie level
// is a synchronous read, then an evaluate step; a command first passes the
// command queue and a start state, and a done state posts the result. A
// lookup visits at most 33 nodes. An insert adds an allocate and a write
// step for each new node it links below an existing one. A two-entry command
// queue in front lets the next transaction be accepted while one is walking,
// and a result register holds the answer until taken; the engine starts
// nothing new while a result waits. Results follow request order; each
// operation sees the tree as left by the one before. No clearing pass is
// needed: nodes are cleared as they are allocated.
module ipv4_prefix_trie_lookup #(
  parameter int NODE_COUNT = iptl_pkg::NODE_COUNT_DEF,
  parameter int TAG_BITS   = iptl_pkg::TAG_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  iptl_pkg::req_t in_data,
  input  logic           in_valid,
  output logic           in_ready,
  output iptl_pkg::rsp_t out_data,
  output logic           out_valid,
  input  logic           out_ready
);

  iptl_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  // Front: accept and queue transactions.
  iptl_front u_front (
    .clk, .rst, .in_data, .in_valid, .in_ready,
    .cmd, .cmd_valid, .cmd_ready
  );

  // Back: walk the trie and post results.
  iptl_engine #(.NODE_COUNT(NODE_COUNT), .TAG_BITS(TAG_BITS)) u_engine (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready,
    .out_data, .out_valid, .out_ready
  );

endmodule

// ===== design/iptl_checker.sv =====
// ----------------------------------------------------------------------------
// iptl_checker
// Port-level checks for the trie lookup block.
// ----------------------------------------------------------------------------
module iptl_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input iptl_pkg::rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.steps <= 6'd33)
    else $error("steps out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != iptl_pkg::ST_OK |-> out_data.tag_out == 16'd0)
    else $error("tag on non-hit");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind ipv4_prefix_trie_lookup iptl_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .out_data
);
